// ===== rtl/read_haplotype_pair_loglikelihood_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the read/haplotype pair log likelihood unit
// Property wrappers for the file that checks this block's logic.
// ----------------------------------------------------------------------------
`ifndef READ_HAPLOTYPE_PAIR_LOGLIKELIHOOD_UNIT_ASSERT_SVH
`define READ_HAPLOTYPE_PAIR_LOGLIKELIHOOD_UNIT_ASSERT_SVH

// The condition implies the expression in the same cycle.
`define RHPL_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The condition implies the expression in the next cycle.
`define RHPL_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/rhpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Read/haplotype pair log likelihood package
// Widths, codes and the log-sum-exp correction table shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rhpl_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int CORR_SHIFT   = FRAC_BITS - 6;
    localparam int TABLE_DEPTH  = 512;
    localparam int TABLE_IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CORR_W       = 12;

    localparam int ALLELE_W     = 4;
    localparam int MARKER_IDX_W = 8;
    localparam int COUNT_W      = 9;
    localparam int LOG_W        = 20;
    localparam int ROW_W        = 32;
    localparam int DIFF_W       = ROW_W + 1;
    localparam int TOTAL_W      = 48;
    localparam int SUM_W        = TOTAL_W + 3;

    localparam logic [ALLELE_W-1:0] MISSING_ALLELE     = ALLELE_W'(9);
    localparam logic [COUNT_W-1:0]  MARKER_COUNT_RESET = COUNT_W'(256);

    localparam longint unsigned Q60_ONE = 64'd1 << 60;

    typedef logic [CORR_W-1:0] corr_rom_t [TABLE_DEPTH];

    // Work to do at the total stage for one item.
    typedef struct packed {
        logic close;   // fold the row sums into the total
        logic clear;   // clear total and clip flag afterwards
        logic emit;    // deliver the total
        logic zero;    // deliver a zero result
    } op_t;

    // (a*b) >> 60 for operands below 2^62.
    function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
        longint unsigned ah;
        longint unsigned al;
        longint unsigned bh;
        longint unsigned bl;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned lo;
        ah  = a >> 32;
        al  = a & 64'hffff_ffff;
        bh  = b >> 32;
        bl  = b & 64'hffff_ffff;
        hi  = ah * bh;
        mid = ah * bl + al * bh;
        lo  = al * bl;
        return (hi << 4) + ((mid + (lo >> 32)) >> 28);
    endfunction

    // Builds round(2^FRAC_BITS * ln(1 + exp(-k/64))) in exact integer math.
    function automatic corr_rom_t build_corr_rom();
        corr_rom_t       rom;
        longint unsigned step;
        longint unsigned term;
        longint unsigned ln2;
        longint unsigned e;
        longint unsigned y;
        longint unsigned lg;
        longint unsigned half_ulp;
        step     = Q60_ONE;
        term     = Q60_ONE;
        ln2      = 64'd0;
        e        = Q60_ONE;
        half_ulp = 64'd1 << (59 - FRAC_BITS);
        for (int n = 1; n <= 20; n++) begin
            term = term / 64'(64 * n);
            if ((n % 2) == 1) begin
                step = step - term;
            end else begin
                step = step + term;
            end
        end
        for (int n = 1; n <= 62; n++) begin
            ln2 = ln2 + (Q60_ONE >> n) / 64'(n);
        end
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            y  = Q60_ONE + e;
            lg = 64'd0;
            if (y >= 2 * Q60_ONE) begin
                lg = Q60_ONE;
                y  = y >> 1;
            end
            for (int i = 1; i <= 56; i++) begin
                y = q60_mul(y, y);
                if (y >= 2 * Q60_ONE) begin
                    y  = y >> 1;
                    lg = lg | (Q60_ONE >> i);
                end
            end
            rom[k] = CORR_W'((q60_mul(lg, ln2) + half_ulp) >> (60 - FRAC_BITS));
            e = q60_mul(e, step);
        end
        return rom;
    endfunction

    localparam corr_rom_t CORR_ROM = build_corr_rom();

    // log(0.5) in Q(FRAC_BITS): the negated first table entry.
    localparam logic signed [CORR_W+1:0] LN_HALF = -$signed({2'b00, CORR_ROM[0]});

endpackage

`default_nettype wire

// ===== rtl/rhpl_corr_rom.sv =====
// ----------------------------------------------------------------------------
// Log-sum-exp correction lookup
// Registered read of the correction table; zero past the end of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module rhpl_corr_rom (
    input  wire logic                            clk,
    input  wire logic                            load,
    input  wire logic [rhpl_pkg::TABLE_IDX_W-1:0] idx,
    input  wire logic                            in_range,
    output logic      [rhpl_pkg::CORR_W-1:0]      corr
);

    logic [rhpl_pkg::CORR_W-1:0] corr_reg;
    logic [rhpl_pkg::CORR_W-1:0] corr_next;

    always_comb begin
        corr_next = in_range ? rhpl_pkg::CORR_ROM[idx] : '0;
    end

    always_ff @(posedge clk) begin
        if (load) begin
            corr_reg <= corr_next;
        end
    end

    assign corr = corr_reg;

endmodule

`default_nettype wire

// ===== rtl/read_haplotype_pair_loglikelihood_unit.sv =====
// ----------------------------------------------------------------------------
// Read/haplotype pair log likelihood unit
// Accumulates per-read match scores for two haplotypes and sums log-sum-exp
// over reads into one saturating Q12 total per haplotype pair.
// ----------------------------------------------------------------------------
// Usage:
// Markers arrive on the in_valid/in_ready channel, one item per marker. Each
// item either adds to the two row sums, closes a read, or ends a pair. A pair
// result (log_likelihood, saturated) leaves on the out_valid/out_ready channel.
// The single register marker_count is written through cfg_valid/cfg_data;
// cfg_ready is always high, and writes are expected only while the unit is idle.
// Throughput is one item per cycle while in_ready is high. The item ending a
// pair passes the input register, read close, max and table index, table
// lookup and total update, then the output register. The critical loops are
// the 32-bit row sum add in stage 1 and the 48-bit total add in the last.
// When the receiver stalls, the pending result holds in the output register;
// items that produce no result keep flowing, and input is refused only once a
// second result stands ready behind the waiting one and the pipe has filled.
// Reset clears the row sums, the total, the clip flag and all valid bits, and
// sets marker_count to 256. The correction table is constant and needs no fill.
// ----------------------------------------------------------------------------
`default_nettype none

module read_haplotype_pair_loglikelihood_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rhpl_pkg::COUNT_W-1:0]       cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               mode,
    input  wire logic                               pair_active,
    input  wire logic [rhpl_pkg::MARKER_IDX_W-1:0]  marker_index,
    input  wire logic [rhpl_pkg::ALLELE_W-1:0]      observed_allele,
    input  wire logic [rhpl_pkg::ALLELE_W-1:0]      first_hap_allele,
    input  wire logic [rhpl_pkg::ALLELE_W-1:0]      second_hap_allele,
    input  wire logic signed [rhpl_pkg::LOG_W-1:0]  match_log,
    input  wire logic signed [rhpl_pkg::LOG_W-1:0]  mismatch_log,
    input  wire logic                               end_of_read,
    input  wire logic                               end_of_pair,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [rhpl_pkg::TOTAL_W-1:0]     log_likelihood,
    output logic                                    saturated
);

    localparam int ROW_W   = rhpl_pkg::ROW_W;
    localparam int TOTAL_W = rhpl_pkg::TOTAL_W;
    localparam int SUM_W   = rhpl_pkg::SUM_W;
    localparam int DIFF_W  = rhpl_pkg::DIFF_W;

    localparam logic signed [ROW_W:0]   ROW_MAX   = (ROW_W+1)'((64'd1 << (ROW_W-1)) - 64'd1);
    localparam logic signed [ROW_W:0]   ROW_MIN   = -(ROW_W+1)'(64'd1 << (ROW_W-1));
    localparam logic signed [SUM_W-1:0] TOTAL_MAX = SUM_W'((64'd1 << (TOTAL_W-1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] TOTAL_MIN = -SUM_W'(64'd1 << (TOTAL_W-1));

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    logic [rhpl_pkg::COUNT_W-1:0] marker_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            marker_count_reg <= rhpl_pkg::MARKER_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            marker_count_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------------
    logic                                v1_reg;
    logic                                mode1_reg;
    logic                                active1_reg;
    logic [rhpl_pkg::MARKER_IDX_W-1:0]   col1_reg;
    logic [rhpl_pkg::ALLELE_W-1:0]       rd1_reg;
    logic [rhpl_pkg::ALLELE_W-1:0]       h1_1_reg;
    logic [rhpl_pkg::ALLELE_W-1:0]       h2_1_reg;
    logic signed [rhpl_pkg::LOG_W-1:0]   match1_reg;
    logic signed [rhpl_pkg::LOG_W-1:0]   mismatch1_reg;
    logic                                eor1_reg;
    logic                                eop1_reg;

    // Row sums, updated as an item leaves stage 1.
    logic signed [ROW_W-1:0] first_row_reg;
    logic signed [ROW_W-1:0] second_row_reg;
    logic signed [ROW_W-1:0] first_row_next;
    logic signed [ROW_W-1:0] second_row_next;

    // Stage 2: closed read sums.
    logic                    v2_reg;
    rhpl_pkg::op_t           op2_reg;
    logic signed [ROW_W-1:0] a2_reg;
    logic signed [ROW_W-1:0] b2_reg;

    // Stage 3: max and table index.
    logic                                v3_reg;
    rhpl_pkg::op_t                       op3_reg;
    logic signed [ROW_W-1:0]             mx3_reg;
    logic [rhpl_pkg::TABLE_IDX_W-1:0]    idx3_reg;
    logic                                in_range3_reg;

    // Stage 4: correction ready, total update.
    logic                        v4_reg;
    rhpl_pkg::op_t               op4_reg;
    logic signed [ROW_W-1:0]     mx4_reg;
    logic [rhpl_pkg::CORR_W-1:0] corr4;

    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [TOTAL_W-1:0] total_next;
    logic                      clip_reg;
    logic                      clip_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [TOTAL_W-1:0] out_total_reg;
    logic signed [TOTAL_W-1:0] out_total_next;
    logic                      out_sat_reg;
    logic                      out_sat_next;

    // ------------------------------------------------------------------------
    // Flow control: each stage moves when the one after it has room; stage 1 items
    // with no work for the later stages move regardless.
    logic          out_free;
    logic          s4_has_result;
    logic          s4_done;
    logic          s4_free;
    logic          s3_free;
    logic          s2_free;
    logic          s1_has_op;
    logic          s1_move;
    rhpl_pkg::op_t op1;

    assign out_free      = !out_valid_reg || out_ready;
    assign s4_has_result = op4_reg.emit || op4_reg.zero;
    assign s4_done       = v4_reg && (!s4_has_result || out_free);
    assign s4_free       = !v4_reg || s4_done;
    assign s3_free       = !v3_reg || s4_free;
    assign s2_free       = !v2_reg || s3_free;
    assign s1_has_op     = op1.close || op1.clear || op1.emit || op1.zero;
    assign s1_move       = v1_reg && (!s1_has_op || s2_free);
    assign in_ready      = !v1_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
        end else if (in_ready) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            mode1_reg     <= mode;
            active1_reg   <= pair_active;
            col1_reg      <= marker_index;
            rd1_reg       <= observed_allele;
            h1_1_reg      <= first_hap_allele;
            h2_1_reg      <= second_hap_allele;
            match1_reg    <= match_log;
            mismatch1_reg <= mismatch_log;
            eor1_reg      <= end_of_read;
            eop1_reg      <= end_of_pair;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1 logic: decode and row sum accumulate with saturation.
    // ------------------------------------------------------------------------
    logic                    use_marker;
    logic                    clear_rows;
    logic signed [ROW_W:0]   first_wide;
    logic signed [ROW_W:0]   second_wide;
    logic signed [ROW_W-1:0] first_acc;
    logic signed [ROW_W-1:0] second_acc;
    logic signed [ROW_W-1:0] first_closed;
    logic signed [ROW_W-1:0] second_closed;

    always_comb begin
        use_marker = active1_reg && !mode1_reg
                     && ({1'b0, col1_reg} < marker_count_reg)
                     && (rd1_reg != rhpl_pkg::MISSING_ALLELE);

        first_wide  = (ROW_W+1)'(first_row_reg)
                      + (ROW_W+1)'((rd1_reg == h1_1_reg) ? match1_reg : mismatch1_reg);
        second_wide = (ROW_W+1)'(second_row_reg)
                      + (ROW_W+1)'((rd1_reg == h2_1_reg) ? match1_reg : mismatch1_reg);

        if (first_wide > ROW_MAX) begin
            first_acc = ROW_MAX[ROW_W-1:0];
        end else if (first_wide < ROW_MIN) begin
            first_acc = ROW_MIN[ROW_W-1:0];
        end else begin
            first_acc = first_wide[ROW_W-1:0];
        end
        if (second_wide > ROW_MAX) begin
            second_acc = ROW_MAX[ROW_W-1:0];
        end else if (second_wide < ROW_MIN) begin
            second_acc = ROW_MIN[ROW_W-1:0];
        end else begin
            second_acc = second_wide[ROW_W-1:0];
        end

        first_closed  = use_marker ? first_acc : first_row_reg;
        second_closed = use_marker ? second_acc : second_row_reg;

        op1 = '0;
        if (mode1_reg) begin
            // A pair without reads: clear everything, report zero if active.
            op1.clear  = 1'b1;
            op1.zero   = active1_reg;
            clear_rows = 1'b1;
        end else if (!active1_reg) begin
            op1.clear  = eop1_reg;
            clear_rows = eor1_reg || eop1_reg;
        end else begin
            op1.close  = eor1_reg || eop1_reg;
            op1.emit   = eop1_reg;
            op1.clear  = eop1_reg;
            clear_rows = eor1_reg || eop1_reg;
        end

        first_row_next  = clear_rows ? '0 : first_closed;
        second_row_next = clear_rows ? '0 : second_closed;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            first_row_reg  <= '0;
            second_row_reg <= '0;
        end else if (s1_move) begin
            first_row_reg  <= first_row_next;
            second_row_reg <= second_row_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: register the sums of the read being closed.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v2_reg  <= 1'b0;
            op2_reg <= '0;
        end else if (s2_free) begin
            v2_reg  <= s1_move && s1_has_op;
            op2_reg <= op1;
        end
    end

    always_ff @(posedge clk) begin
        if (s2_free) begin
            a2_reg <= first_closed;
            b2_reg <= second_closed;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2 logic: max and absolute difference of the two sums.
    // ------------------------------------------------------------------------
    logic                             a_gt;
    logic signed [ROW_W-1:0]          mx2;
    logic [DIFF_W-1:0]                diff2;
    logic [DIFF_W-1:0]                idx_full2;
    logic                             in_range2;

    always_comb begin
        a_gt      = a2_reg > b2_reg;
        mx2       = a_gt ? a2_reg : b2_reg;
        diff2     = a_gt ? DIFF_W'(DIFF_W'(a2_reg) - DIFF_W'(b2_reg))
                         : DIFF_W'(DIFF_W'(b2_reg) - DIFF_W'(a2_reg));
        idx_full2 = diff2 >> rhpl_pkg::CORR_SHIFT;
        in_range2 = idx_full2 < DIFF_W'(rhpl_pkg::TABLE_DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v3_reg  <= 1'b0;
            op3_reg <= '0;
        end else if (s3_free) begin
            v3_reg  <= v2_reg;
            op3_reg <= op2_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (s3_free) begin
            mx3_reg       <= mx2;
            idx3_reg      <= idx_full2[rhpl_pkg::TABLE_IDX_W-1:0];
            in_range3_reg <= in_range2;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: correction table lookup.
    // ------------------------------------------------------------------------
    rhpl_corr_rom u_corr_rom (
        .clk      (clk),
        .load     (s4_free),
        .idx      (idx3_reg),
        .in_range (in_range3_reg),
        .corr     (corr4)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v4_reg  <= 1'b0;
            op4_reg <= '0;
        end else if (s4_free) begin
            v4_reg  <= v3_reg;
            op4_reg <= op3_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (s4_free) begin
            mx4_reg <= mx3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: saturating total update and result capture.
    // ------------------------------------------------------------------------
    logic signed [SUM_W-1:0]   sum4;
    logic signed [TOTAL_W-1:0] closed_total;
    logic                      closed_clip;

    always_comb begin
        sum4 = SUM_W'(total_reg) + SUM_W'(rhpl_pkg::LN_HALF) + SUM_W'(mx4_reg)
               + $signed(SUM_W'(corr4));

        closed_total = total_reg;
        closed_clip  = clip_reg;
        if (op4_reg.close) begin
            if (sum4 > TOTAL_MAX) begin
                closed_total = TOTAL_MAX[TOTAL_W-1:0];
                closed_clip  = 1'b1;
            end else if (sum4 < TOTAL_MIN) begin
                closed_total = TOTAL_MIN[TOTAL_W-1:0];
                closed_clip  = 1'b1;
            end else begin
                closed_total = sum4[TOTAL_W-1:0];
            end
        end

        total_next = total_reg;
        clip_next  = clip_reg;
        if (s4_done) begin
            total_next = op4_reg.clear ? '0 : closed_total;
            clip_next  = op4_reg.clear ? 1'b0 : closed_clip;
        end

        out_valid_next = out_valid_reg && !out_ready;
        out_total_next = out_total_reg;
        out_sat_next   = out_sat_reg;
        if (s4_done && s4_has_result) begin
            out_valid_next = 1'b1;
            out_total_next = op4_reg.zero ? '0 : closed_total;
            out_sat_next   = op4_reg.zero ? 1'b0 : closed_clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            total_reg     <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            total_reg     <= total_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        out_total_reg <= out_total_next;
        out_sat_reg   <= out_sat_next;
    end

    assign out_valid      = out_valid_reg;
    assign log_likelihood = out_total_reg;
    assign saturated      = out_sat_reg;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
`include "read_haplotype_pair_loglikelihood_unit_assert.svh"

    // A pair without reads must come out as a clean zero.
    `RHPL_ASSERT_NEXT(a_zero_result, clk, rst_n, s4_done && op4_reg.zero,
        out_valid && (log_likelihood == '0) && !saturated,
        "no-read pair did not produce a zero result")

    // Closing a read must leave both row sums empty.
    `RHPL_ASSERT_NEXT(a_rows_cleared, clk, rst_n, s1_move && op1.close,
        (first_row_reg == '0) && (second_row_reg == '0),
        "row sums not cleared after a read closed")

    // Delivering a pair result must reset the total and the clip flag.
    `RHPL_ASSERT_NEXT(a_total_cleared, clk, rst_n, s4_done && s4_has_result,
        (total_reg == '0) && !clip_reg,
        "pair total not cleared after its result")

    // A new result is only loaded from a finishing item that carries one.
    `RHPL_ASSERT_NOW(a_result_source, clk, rst_n, $rose(out_valid_reg),
        $past(s4_done && s4_has_result),
        "result appeared without an item ending a pair")

endmodule

`default_nettype wire
